// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checksum core, sampled on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: expression does not hold");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: consequent missing one cycle later");

`endif

// ===== rtl/core/adl32sk_pkg.sv =====
// Types and constants of the Adler-32 skip-window checksum core.
package adl32sk_pkg;

   localparam int SumWidth      = 16;
   localparam int PosWidth      = 9;
   localparam int ByteWidth     = 8;
   localparam int ChecksumWidth = 2 * SumWidth;

   typedef logic [SumWidth-1:0]      sum_type;
   typedef logic [PosWidth-1:0]      pos_type;
   typedef logic [ByteWidth-1:0]     byte_type;
   typedef logic [ChecksumWidth-1:0] checksum_type;

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      CSR_SKIP_FIRST = 1'b0,
      CSR_SKIP_COUNT = 1'b1
   } csr_index_type;

   localparam sum_type  ADLER_MOD       = sum_type'(65521);
   localparam sum_type  LOW_SUM_RESET   = sum_type'(1);
   localparam sum_type  HIGH_SUM_RESET  = sum_type'(0);
   localparam pos_type  POS_MAX         = '1;
   localparam byte_type SKIP_FIRST_RESET = byte_type'(8);
   localparam byte_type SKIP_COUNT_RESET = byte_type'(4);

endpackage

// ===== rtl/core/adl32sk_ifs.sv =====
// Valid/ready channel interfaces for the request bytes and the checksum words.
interface adl32sk_req_if;
   import adl32sk_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface adl32sk_rsp_if;
   import adl32sk_pkg::*;

   logic         valid;
   logic         ready;
   checksum_type checksum;

   modport source (output valid, output checksum, input ready);
   modport sink   (input valid, input checksum, output ready);
endinterface

// ===== rtl/core/adler32_with_skip_window_core.sv =====
// Adler-32 checksum core with a configurable skip window over byte positions.
// The checksum word appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while the output slot is free or its word is taken.
// Reset (synchronous, active high): sums to 1 and 0, position to 0, window to 8..11.
// The running sums update in one pass: two 17-bit add and conditional-subtract steps.
module adler32_with_skip_window_core (
   input  logic                      clock,
   input  logic                      reset,
   adl32sk_req_if.sink               req_bus,
   adl32sk_rsp_if.source             rsp_bus,
   input  logic                      csr_wr_en,
   input  adl32sk_pkg::csr_index_type csr_index,
   input  adl32sk_pkg::byte_type     csr_wr_data
);
   import adl32sk_pkg::*;

   `include "assert_macros.svh"

   // Configuration registers
   byte_type skip_first_ff, skip_first_in;
   byte_type skip_count_ff, skip_count_in;

   // Running message state
   sum_type low_sum_ff,  low_sum_in;
   sum_type high_sum_ff, high_sum_in;
   pos_type byte_pos_ff, byte_pos_in;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   checksum_type checksum_ff,  checksum_in;

   logic                req_accept;
   logic                in_window;
   logic [PosWidth-1:0] window_end;
   logic [SumWidth:0]   low_raw;
   logic [SumWidth:0]   high_raw;
   sum_type             low_upd;
   sum_type             high_upd;
   sum_type             low_new;
   sum_type             high_new;
   logic                msg_state_clear;

   // Take a new byte whenever the output slot is empty or being emptied.
   assign req_bus.ready    = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept       = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.checksum = checksum_ff;

   // Configuration writes; every index of the port names a register.
   always_comb begin
      skip_first_in = skip_first_ff;
      skip_count_in = skip_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SKIP_FIRST: skip_first_in = csr_wr_data;
            CSR_SKIP_COUNT: skip_count_in = csr_wr_data;
            default:        skip_first_in = skip_first_ff;
         endcase
      end
   end

   // Window covers positions skip_first up to skip_first + skip_count - 1.
   // The end never exceeds 510, so a saturated position always falls outside.
   always_comb begin
      window_end = {1'b0, skip_first_ff} + {1'b0, skip_count_ff};
      in_window  = (byte_pos_ff >= {1'b0, skip_first_ff}) && (byte_pos_ff < window_end);
   end

   // Both sums stay below the modulus, so one conditional subtract reduces each.
   always_comb begin
      low_raw  = {1'b0, low_sum_ff} + {{(SumWidth + 1 - ByteWidth){1'b0}}, req_bus.data_byte};
      low_upd  = (low_raw >= {1'b0, ADLER_MOD}) ? sum_type'(low_raw - {1'b0, ADLER_MOD})
                                                 : low_raw[SumWidth-1:0];
      high_raw = {1'b0, high_sum_ff} + {1'b0, low_upd};
      high_upd = (high_raw >= {1'b0, ADLER_MOD}) ? sum_type'(high_raw - {1'b0, ADLER_MOD})
                                                  : high_raw[SumWidth-1:0];
      // Hold both sums for a byte inside the window.
      low_new  = in_window ? low_sum_ff  : low_upd;
      high_new = in_window ? high_sum_ff : high_upd;
   end

   // Advance the message state on each accepted byte; clear it after the last byte.
   always_comb begin
      low_sum_in  = low_sum_ff;
      high_sum_in = high_sum_ff;
      byte_pos_in = byte_pos_ff;
      if (req_accept) begin
         if (req_bus.last_byte) begin
            low_sum_in  = LOW_SUM_RESET;
            high_sum_in = HIGH_SUM_RESET;
            byte_pos_in = '0;
         end else begin
            low_sum_in  = low_new;
            high_sum_in = high_new;
            // Saturate the position counter at its top value.
            if (byte_pos_ff != POS_MAX) begin
               byte_pos_in = byte_pos_ff + pos_type'(1);
            end
         end
      end
   end

   // Load the output word on a last byte; drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      checksum_in  = checksum_ff;
      priority if (req_accept && req_bus.last_byte) begin
         rsp_valid_in = 1'b1;
         checksum_in  = {high_new, low_new};
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_first_ff <= SKIP_FIRST_RESET;
         skip_count_ff <= SKIP_COUNT_RESET;
         low_sum_ff    <= LOW_SUM_RESET;
         high_sum_ff   <= HIGH_SUM_RESET;
         byte_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         skip_first_ff <= skip_first_in;
         skip_count_ff <= skip_count_in;
         low_sum_ff    <= low_sum_in;
         high_sum_ff   <= high_sum_in;
         byte_pos_ff   <= byte_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      checksum_ff <= checksum_in;
   end

   // Message state sitting at its starting values.
   assign msg_state_clear = (byte_pos_ff == '0) && (low_sum_ff == LOW_SUM_RESET) &&
                            (high_sum_ff == HIGH_SUM_RESET);

   // Sums must stay reduced for the single-subtract update to be exact.
   `ASSERT_ALWAYS(a_sums_reduced, (low_sum_ff < ADLER_MOD) && (high_sum_ff < ADLER_MOD))
   // A last byte always leaves a checksum word waiting.
   `ASSERT_NEXT(a_last_gives_word, req_accept && req_bus.last_byte, rsp_valid_ff)
   // A last byte returns the message state to its starting values.
   `ASSERT_NEXT(a_last_clears, req_accept && req_bus.last_byte, msg_state_clear)

endmodule

// ===== bench/adler32_with_skip_window_core_tb.sv =====
// Self-checking bench for the Adler-32 skip-window checksum core: predicted words against the DUT.
module adler32_with_skip_window_core_tb;
   import adl32sk_pkg::*;

   // Cycles with no word moving on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;
   // Length of the long receiver hold-off that backs the core up.
   localparam int HOLD_OFF_LEN   = 300;
   // Quiet cycles before a window write once all words are home.
   localparam int SETTLE_CYCLES  = 3;

   // Running Adler-32 prediction and the queue of checksum words still owed.
   class checksum_scoreboard;
      byte_type     window_first;
      byte_type     window_count;
      sum_type      low_sum;
      sum_type      high_sum;
      pos_type      position;
      checksum_type owed_words[$];
      int           error_count;

      function new();
         window_first = SKIP_FIRST_RESET;
         window_count = SKIP_COUNT_RESET;
         clear_message();
         error_count  = 0;
      endfunction

      function void clear_message();
         low_sum  = LOW_SUM_RESET;
         high_sum = HIGH_SUM_RESET;
         position = '0;
      endfunction

      function void set_register(csr_index_type index, byte_type value);
         case (index)
            CSR_SKIP_FIRST: window_first = value;
            CSR_SKIP_COUNT: window_count = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      // Fold one accepted byte into the sums; owe a word on the last byte.
      function void note_byte(byte_type data, logic last);
         int unsigned next_low;
         int unsigned next_high;
         bit          in_window;
         in_window = int'(position) >= int'(window_first) &&
                     int'(position) < int'(window_first) + int'(window_count);
         if (!in_window) begin
            next_low = int'(low_sum) + int'(data);
            if (next_low >= int'(ADLER_MOD)) next_low -= int'(ADLER_MOD);
            next_high = int'(high_sum) + next_low;
            if (next_high >= int'(ADLER_MOD)) next_high -= int'(ADLER_MOD);
            low_sum  = sum_type'(next_low);
            high_sum = sum_type'(next_high);
         end
         if (position != POS_MAX) position++;
         if (last) begin
            owed_words.push_back({high_sum, low_sum});
            clear_message();
         end
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("%0t: checksum mismatch: %s", $time, what);
      endtask

      task check_checksum(checksum_type got);
         checksum_type want;
         if (owed_words.size() == 0) begin
            report_mismatch($sformatf("word %h arrived with nothing owed", got));
         end else begin
            want = owed_words.pop_front();
            if (got !== want)
               report_mismatch($sformatf("checksum %h, predicted %h", got, want));
         end
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   byte_type      csr_wr_data;

   adl32sk_req_if req_bus ();
   adl32sk_rsp_if rsp_bus ();

   // Idling knobs for the sender task and the receiver process.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_left      = 0;

   checksum_scoreboard checksums = new();

   adler32_with_skip_window_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the edge; note the byte before checking the word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            checksums.note_byte(req_bus.data_byte, req_bus.last_byte);
         if (rsp_bus.valid && rsp_bus.ready)
            checksums.check_checksum(rsp_bus.checksum);
      end
   end

   // Receiver: hold off for the requested stretch, otherwise stall at random.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: abandon the run if no word moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Offer one byte, after a random idle gap, and hold it until it is taken.
   task automatic send_byte(byte_type data, logic last);
      int gap;
      gap = 0;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Bias towards the extremes; a heavy byte is mostly 0xFF to push the low sum past the modulus.
   function automatic byte_type random_byte(bit heavy);
      int pick;
      pick = $urandom_range(99);
      if (heavy) return (pick < 90) ? 8'hFF : byte_type'($urandom);
      if (pick < 10) return 8'h00;
      if (pick < 20) return 8'hFF;
      return byte_type'($urandom);
   endfunction

   // Mostly short messages, so small windows are crossed often.
   function automatic int random_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $urandom_range(1, 12);
      if (pick < 90) return $urandom_range(13, 40);
      return $urandom_range(41, 80);
   endfunction

   task automatic send_message(int len, bit heavy);
      for (int i = 0; i < len; i++) send_byte(random_byte(heavy), i == len - 1);
   endtask

   // Let the monitor see the last accepted byte, wait for every owed word, then settle.
   task automatic drain();
      @(posedge clock);
      while (checksums.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both window registers on consecutive edges; the enable stays high across them.
   task automatic write_window(byte_type first, byte_type count);
      csr_index   <= CSR_SKIP_FIRST;
      csr_wr_data <= first;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      checksums.set_register(CSR_SKIP_FIRST, first);
      csr_index   <= CSR_SKIP_COUNT;
      csr_wr_data <= count;
      @(posedge clock);
      checksums.set_register(CSR_SKIP_COUNT, count);
      csr_wr_en   <= 1'b0;
   endtask

   // One phase: new window, new idling, an optional long message, then random messages.
   task automatic run_phase(byte_type first, byte_type count, int idle_pct, int stall_pct,
                            int items, int long_len, bit heavy_long, bit pressure);
      int sent;
      int len;
      drain();
      write_window(first, count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (pressure) hold_off_left = HOLD_OFF_LEN;
      if (long_len > 0) send_message(long_len, heavy_long);
      sent = 0;
      while (sent < items) begin
         len = random_length();
         send_message(len, 1'b0);
         sent += len;
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_SKIP_FIRST;
      csr_wr_data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset window of bytes 8 to 11, no idling.
      // Single-byte messages at both byte extremes.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // Message straddling the window, last byte just past it.
      for (int i = 0; i < 13; i++)
         send_byte(i[0] ? 8'hFF : byte_type'(i * 17), i == 12);
      // Last byte inside the window: skip it, still expect the word.
      for (int i = 0; i < 10; i++)
         send_byte(byte_type'(8'h80 + i), i == 9);
      req_bus.valid <= 1'b0;

      // Skip only the first byte, no idling.
      run_phase(8'd0, 8'd1, 0, 0, 100, 0, 1'b0, 1'b0);
      // Widest late window, crossed and left by a long message past saturation.
      run_phase(8'd255, 8'd255, 76, 0, 50, 520, 1'b0, 1'b0);
      // Skipping off; heavy long message drives both sums through the modulus.
      run_phase(8'd0, 8'd0, 0, 76, 50, 530, 1'b1, 1'b0);
      // Small random window, light idling, long hold-off so the input backs up.
      run_phase(byte_type'($urandom_range(0, 30)), byte_type'($urandom_range(0, 20)),
                12, 12, 100, 0, 1'b0, 1'b1);
      // Window starting at the top with count zero, no idling.
      run_phase(8'd255, 8'd0, 0, 0, 100, 0, 1'b0, 1'b0);
      // Full-range random window, heavy idling on both sides.
      run_phase(byte_type'($urandom), byte_type'($urandom), 76, 76, 100, 0, 1'b0, 1'b0);
      // Window from position zero covering the first 255 bytes.
      run_phase(8'd0, 8'd255, 12, 12, 100, 0, 1'b0, 1'b0);

      drain();
      if (checksums.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== adler32_with_skip_window_core.f =====
+incdir+rtl/core
rtl/core/adl32sk_pkg.sv
rtl/core/adl32sk_ifs.sv
rtl/core/adler32_with_skip_window_core.sv
bench/adler32_with_skip_window_core_tb.sv
